// ----- src/utwl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 text wrap layout block.
package utwl_pkg;

	// Glyph geometry in pixels.
	localparam int GLYPH_SIZE   = 16;
	localparam int NARROW_WIDTH = 8;

	// Depth of the queue between the decoder and the layout engine.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// Special code points.
	localparam logic [15:0] REPL_CHAR = 16'hFFFD;
	localparam logic [15:0] CP_CR     = 16'h000D;
	localparam logic [15:0] CP_LF     = 16'h000A;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
	localparam logic [1:0] REG_BOX_WIDTH  = 2'd2;
	localparam logic [1:0] REG_BOX_HEIGHT = 2'd3;

	// Text box geometry as seen by the layout engine.
	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
	} cfg_t;

	// Decoded characters of one input byte, in order, and the end-of-text mark.
	typedef struct packed {
		logic [2:0][15:0] cp;
		logic [1:0]       count;
		logic             flush;
	} ent_t;

	// One placed glyph.
	typedef struct packed {
		logic [15:0] code_point;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [4:0]  glyph_width;
		logic        glyph_class;
	} res_t;

endpackage

// ----- src/utf8_text_wrap_layout_top.sv -----
`timescale 1ns / 1ps
// Top level of the UTF-8 text wrap layout block: configuration registers and the two halves.
//
// This block takes UTF-8 text one byte per transaction on the input channel, decodes
// one- to three-byte sequences (a broken sequence gives U+FFFD for its lead byte and the
// following bytes are scanned again), and lays the characters out in a text box whose
// origin and size come from four 16-bit registers on the APB-style port (origin_x at 0x0,
// origin_y at 0x4, box_width at 0x8, box_height at 0xC). Each drawn glyph leaves as one
// output transaction with its position, width and class; run_last marks the last glyph
// caused by an input byte, and a byte may cause none. A zero byte or end_of_text ends the
// text: pending bytes are flushed and the next byte starts again at the box origin.
// The decoder takes a byte in every cycle while its four-entry queue has room; the layout
// engine behind the queue places one character per cycle unless the output stalls, so the
// rare byte that releases two or three characters is walked one character at a time there
// and the queue hides it. Between an accepted byte and its glyph on the output lie the
// queue, the hold register and the output register; each glyph waits in the hold register
// until the engine knows whether it closes its byte's run.
// The user must write the registers only while no text is in flight; the block does not enforce it.
module utf8_text_wrap_layout_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Text input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	// Glyph output channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_point,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [4:0]  glyph_width,
	output logic        glyph_class,
	output logic        run_last
);

	utwl_pkg::cfg_t cfg_q;
	logic           cfg_wr;
	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_valid;
	utwl_pkg::ent_t q_din;
	utwl_pkg::ent_t q_dout;
	utwl_pkg::res_t res;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x   <= 16'd0;
			cfg_q.origin_y   <= 16'd0;
			cfg_q.box_width  <= 16'd240;
			cfg_q.box_height <= 16'd240;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				utwl_pkg::REG_ORIGIN_X:   cfg_q.origin_x   <= pwdata[15:0];
				utwl_pkg::REG_ORIGIN_Y:   cfg_q.origin_y   <= pwdata[15:0];
				utwl_pkg::REG_BOX_WIDTH:  cfg_q.box_width  <= pwdata[15:0];
				utwl_pkg::REG_BOX_HEIGHT: cfg_q.box_height <= pwdata[15:0];
				default:                  cfg_q.origin_x   <= cfg_q.origin_x;
			endcase
		end
	end

	// Register read-back, zero-extended to the bus width.
	always_comb begin
		case (paddr[3:2])
			utwl_pkg::REG_ORIGIN_X:   prdata = {16'h0000, cfg_q.origin_x};
			utwl_pkg::REG_ORIGIN_Y:   prdata = {16'h0000, cfg_q.origin_y};
			utwl_pkg::REG_BOX_WIDTH:  prdata = {16'h0000, cfg_q.box_width};
			utwl_pkg::REG_BOX_HEIGHT: prdata = {16'h0000, cfg_q.box_height};
			default:                  prdata = 32'h0000_0000;
		endcase
	end

	// The decoder keeps the pending bytes of an unfinished sequence and emits one entry
	// per accepted byte, holding zero to three characters.
	utwl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_din       (q_din)
	);

	utwl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	// The layout engine owns the cursor and the box-full flag and walks each entry one
	// character per cycle while the output does not stall.
	utwl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.ent       (q_dout),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res),
		.out_last  (run_last)
	);

	assign code_point  = res.code_point;
	assign pos_x       = res.pos_x;
	assign pos_y       = res.pos_y;
	assign glyph_width = res.glyph_width;
	assign glyph_class = res.glyph_class;

endmodule

// ----- src/utwl_front.sv -----
`timescale 1ns / 1ps
// UTF-8 decoder front end: accepts bytes and turns them into character entries.
module utwl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	input  logic               q_full,
	output logic               q_push,
	output utwl_pkg::ent_t     q_din
);

	logic [7:0]  pending_lead_q;
	logic [7:0]  pending_cont_q;
	logic [1:0]  pending_count_q;

	logic [7:0]  bb [4];
	logic [1:0]  nb;
	logic [1:0]  pos;
	logic [1:0]  ncp;
	logic [1:0]  adv;
	logic [1:0]  avail;
	logic [1:0]  idx1;
	logic [1:0]  idx2;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [15:0] cp_v;
	logic        stop;
	logic        hit;
	logic        term;
	logic        flush;
	logic [2:0][15:0] cps;
	logic [1:0]  rem;
	logic [1:0]  pcnt_next;
	logic [7:0]  lead_next;
	logic [7:0]  cont_next;

	assign term     = (text_byte == 8'h00);
	assign flush    = end_of_text || term;
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// Gather the pending bytes and the new one, then scan them as leads.
	always_comb begin
		bb[0] = 8'h00;
		bb[1] = 8'h00;
		bb[2] = 8'h00;
		bb[3] = 8'h00;
		case (pending_count_q)
			2'd1: begin
				bb[0] = pending_lead_q;
				bb[1] = text_byte;
				nb    = term ? 2'd1 : 2'd2;
			end
			2'd2: begin
				bb[0] = pending_lead_q;
				bb[1] = pending_cont_q;
				bb[2] = text_byte;
				nb    = term ? 2'd2 : 2'd3;
			end
			default: begin
				bb[0] = text_byte;
				nb    = term ? 2'd0 : 2'd1;
			end
		endcase

		pos   = 2'd0;
		ncp   = 2'd0;
		stop  = 1'b0;
		cps   = '0;
		adv   = 2'd0;
		avail = 2'd0;
		idx1  = 2'd0;
		idx2  = 2'd0;
		b0    = 8'h00;
		b1    = 8'h00;
		b2    = 8'h00;
		cp_v  = 16'h0000;
		hit   = 1'b0;
		// Every character consumes at least one byte, so three passes cover the buffer.
		for (int i = 0; i < 3; i++) begin
			if (!stop && (pos < nb)) begin
				idx1  = pos + 2'd1;
				idx2  = pos + 2'd2;
				b0    = bb[pos];
				b1    = bb[idx1];
				b2    = bb[idx2];
				avail = nb - pos;
				hit   = 1'b1;
				adv   = 2'd1;
				cp_v  = utwl_pkg::REPL_CHAR;
				if (b0 < 8'h80) begin
					cp_v = {8'h00, b0};
				end else if ((b0 & 8'hE0) == 8'hC0) begin
					if (avail < 2'd2) begin
						if (!flush) begin
							stop = 1'b1;
							hit  = 1'b0;
						end
					end else if ((b1 & 8'hC0) == 8'h80) begin
						cp_v = {5'd0, b0[4:0], b1[5:0]};
						adv  = 2'd2;
					end
				end else if ((b0 & 8'hF0) == 8'hE0) begin
					if (avail < 2'd2) begin
						if (!flush) begin
							stop = 1'b1;
							hit  = 1'b0;
						end
					end else if ((b1 & 8'hC0) != 8'h80) begin
						cp_v = utwl_pkg::REPL_CHAR;
					end else if (avail < 2'd3) begin
						if (!flush) begin
							stop = 1'b1;
							hit  = 1'b0;
						end
					end else if ((b2 & 8'hC0) == 8'h80) begin
						cp_v = {b0[3:0], b1[5:0], b2[5:0]};
						adv  = 2'd3;
					end
				end
				if (hit) begin
					cps[ncp] = cp_v;
					ncp      = ncp + 2'd1;
					pos      = pos + adv;
				end
			end
		end

		// Whatever is left waits for the next byte, at most a lead and one continuation.
		rem       = nb - pos;
		pcnt_next = (rem > 2'd2) ? 2'd2 : rem;
		idx1      = pos + 2'd1;
		lead_next = (pcnt_next >= 2'd1) ? bb[pos] : 8'h00;
		cont_next = (pcnt_next >= 2'd2) ? bb[idx1] : 8'h00;
		if (flush) begin
			pcnt_next = 2'd0;
			lead_next = 8'h00;
			cont_next = 8'h00;
		end
	end

	assign q_din.cp    = cps;
	assign q_din.count = ncp;
	assign q_din.flush = flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_lead_q  <= 8'h00;
			pending_cont_q  <= 8'h00;
			pending_count_q <= 2'd0;
		end else if (q_push) begin
			pending_lead_q  <= lead_next;
			pending_cont_q  <= cont_next;
			pending_count_q <= pcnt_next;
		end
	end

endmodule

// ----- src/utwl_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO of decoded character entries between the decoder and the layout engine.
module utwl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  utwl_pkg::ent_t din,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output utwl_pkg::ent_t dout
);

	utwl_pkg::ent_t                mem_q [utwl_pkg::Q_DEPTH];
	logic [utwl_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [utwl_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [utwl_pkg::Q_AW:0]       count_q;
	logic                          do_pop;

	assign full   = (count_q == (utwl_pkg::Q_AW+1)'(utwl_pkg::Q_DEPTH));
	assign valid  = (count_q != '0);
	assign dout   = mem_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (utwl_pkg::Q_AW)'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + (utwl_pkg::Q_AW)'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (utwl_pkg::Q_AW+1)'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - (utwl_pkg::Q_AW+1)'(1);
			end
		end
	end

endmodule

// ----- src/utwl_back.sv -----
`timescale 1ns / 1ps
// Layout engine: places queued characters in the text box and drives the result channel.
module utwl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  utwl_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  utwl_pkg::ent_t ent,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output utwl_pkg::res_t out_res,
	output logic           out_last
);

	localparam logic [17:0] GS18   = 18'(utwl_pkg::GLYPH_SIZE);
	localparam logic [17:0] GS2_18 = 18'(2 * utwl_pkg::GLYPH_SIZE);
	localparam logic [17:0] NW18   = 18'(utwl_pkg::NARROW_WIDTH);

	logic [1:0]      k_q;
	logic [16:0]     cursor_x_q;
	logic [16:0]     cursor_y_q;
	logic            box_full_q;
	logic            in_text_q;
	logic            p_valid_q;
	logic            p_closed_q;
	utwl_pkg::res_t  p_res_q;
	logic            o_valid_q;
	logic            o_last_q;
	utwl_pkg::res_t  o_res_q;

	logic            start;
	logic [16:0]     cx;
	logic [16:0]     cy;
	logic            full;
	logic [17:0]     x_end;
	logic [17:0]     y_end;
	logic            has_char;
	logic [15:0]     cp;
	logic            narrow;
	logic [17:0]     w18;
	logic [17:0]     cx_w;
	logic [17:0]     ox_w;
	logic [17:0]     cy_gs;
	logic [17:0]     cy_gs2;
	logic            small_box;
	logic [16:0]     nx;
	logic [16:0]     ny;
	logic            nfull;
	logic            emit;
	utwl_pkg::res_t  res;
	logic            last_char;
	logic            o_free;
	logic            go;
	logic            o_load;

	always_comb begin
		start     = (k_q == 2'd0) && !in_text_q;
		cx        = start ? {1'b0, cfg.origin_x} : cursor_x_q;
		cy        = start ? {1'b0, cfg.origin_y} : cursor_y_q;
		full      = start ? 1'b0 : box_full_q;
		x_end     = {2'b00, cfg.origin_x} + {2'b00, cfg.box_width};
		y_end     = {2'b00, cfg.origin_y} + {2'b00, cfg.box_height};
		has_char  = (ent.count != 2'd0);
		cp        = ent.cp[k_q];
		narrow    = (cp < 16'h0080);
		w18       = narrow ? NW18 : GS18;
		cx_w      = {1'b0, cx} + w18;
		ox_w      = {2'b00, cfg.origin_x} + w18;
		cy_gs     = {1'b0, cy} + GS18;
		cy_gs2    = {1'b0, cy} + GS2_18;
		small_box = ({1'b0, cfg.box_width} < 17'(utwl_pkg::NARROW_WIDTH)) ||
		            ({1'b0, cfg.box_height} < 17'(utwl_pkg::GLYPH_SIZE));

		nx    = cx;
		ny    = cy;
		nfull = full;
		emit  = 1'b0;
		res.code_point  = cp;
		res.pos_x       = cx[15:0];
		res.pos_y       = cy[15:0];
		res.glyph_width = narrow ? 5'(utwl_pkg::NARROW_WIDTH) : 5'(utwl_pkg::GLYPH_SIZE);
		res.glyph_class = !((cp >= 16'h0020) && (cp <= 16'h007E));

		if (has_char && !small_box && !full) begin
			if (cy_gs > y_end) begin
				nfull = 1'b1;
			end else if (cp == utwl_pkg::CP_CR) begin
				nx = cx;
			end else if (cp == utwl_pkg::CP_LF) begin
				nx = {1'b0, cfg.origin_x};
				ny = cy_gs[16:0];
			end else if (cx_w > x_end) begin
				// Wrap to the next row; the row after the wrap may not fit.
				nx = {1'b0, cfg.origin_x};
				ny = cy_gs[16:0];
				if (cy_gs2 > y_end) begin
					nfull = 1'b1;
				end else begin
					emit      = 1'b1;
					res.pos_x = cfg.origin_x;
					res.pos_y = cy_gs[15:0];
					nx        = ox_w[16:0];
				end
			end else begin
				emit = 1'b1;
				nx   = cx_w[16:0];
			end
		end

		last_char = !has_char || (k_q == (ent.count - 2'd1));
		o_free    = !o_valid_q || out_ready;
		go        = q_valid && (!p_valid_q || o_free);
		o_load    = p_valid_q && o_free && (p_closed_q || (go && emit));
	end

	assign q_pop     = go && last_char;
	assign out_valid = o_valid_q;
	assign out_res   = o_res_q;
	assign out_last  = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= 2'd0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			box_full_q <= 1'b0;
			in_text_q  <= 1'b0;
			p_valid_q  <= 1'b0;
			p_closed_q <= 1'b0;
			o_valid_q  <= 1'b0;
			o_last_q   <= 1'b0;
		end else begin
			if (go) begin
				cursor_x_q <= nx;
				cursor_y_q <= ny;
				box_full_q <= nfull;
				in_text_q  <= last_char ? !ent.flush : 1'b1;
				k_q        <= last_char ? 2'd0 : (k_q + 2'd1);
			end
			if (go && emit) begin
				p_valid_q  <= 1'b1;
				p_closed_q <= last_char;
			end else if (o_load) begin
				p_valid_q  <= 1'b0;
				p_closed_q <= 1'b0;
			end else if (go && last_char && p_valid_q) begin
				p_closed_q <= 1'b1;
			end
			if (o_load) begin
				o_valid_q <= 1'b1;
				o_last_q  <= p_closed_q;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			p_res_q <= res;
		end
		if (o_load) begin
			o_res_q <= p_res_q;
		end
	end

	a_closed_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(p_valid_q && p_closed_q && !o_free) |=> p_valid_q)
		else $error("closed held glyph lost while the output stalled");

	a_index_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && (ent.count != 2'd0)) |-> (k_q < ent.count))
		else $error("character index beyond the entry");

	a_mid_entry_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != 2'd0) |-> (in_text_q && q_valid))
		else $error("mid-entry position without a live entry");

	a_held_before_out: assert property (@(posedge clk) disable iff (!arst_n)
		o_load |=> (o_valid_q && (o_last_q == $past(p_closed_q))))
		else $error("output register did not take the held glyph");

endmodule
